// File: design/rkcf_pkg.sv
// ----------------------------------------------------------------------------
// rkcf_pkg
// Shared types, constants and kernel weights of the rgb kernel convolution
// filter.
// ----------------------------------------------------------------------------
package rkcf_pkg;

    localparam int COLOR_BITS          = 8;
    localparam int MAX_LINE_LENGTH_DEF = 1024;
    localparam int MODE_W              = 3;
    localparam int LEN_REG_W           = 11;
    localparam int CNT_REG_W           = 16;
    localparam int CFG_IDX_W           = 2;
    localparam int CFG_DATA_W          = 16;
    localparam int ROW_W               = 18;
    localparam int SUM_W               = 20;
    localparam int WGT_W               = 10;
    localparam int TAPS                = 25;
    localparam int KSIZE               = 5;
    localparam int SLOTS               = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_RIDGE   = 3'd0,
        MODE_EDGE    = 3'd1,
        MODE_SHARPEN = 3'd2,
        MODE_BOX     = 3'd3,
        MODE_GAUSS3  = 3'd4,
        MODE_GAUSS5  = 3'd5,
        MODE_UNSHARP = 3'd6,
        MODE_COPY    = 3'd7
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_MODE = 2'd0,
        CFG_LINE_LENGTH = 2'd1,
        CFG_LINE_COUNT  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
    } t_pixel;

    // per item control carried along the pipeline
    typedef struct packed {
        logic  res;
        t_mode mode;
        logic  inner;
        logic  last;
    } t_res_ctrl;

    typedef logic signed [WGT_W-1:0] t_weight;

    // kernel weights, row major, one row per mode (copy row unused)
    localparam t_weight KERNEL [8][TAPS] = '{
        '{ 0,0,0,0,0,  0,0,-1,0,0,  0,-1,4,-1,0,  0,0,-1,0,0,  0,0,0,0,0 },
        '{ 0,0,0,0,0,  0,-1,-1,-1,0,  0,-1,8,-1,0,  0,-1,-1,-1,0,  0,0,0,0,0 },
        '{ 0,0,0,0,0,  0,0,-1,0,0,  0,-1,5,-1,0,  0,0,-1,0,0,  0,0,0,0,0 },
        '{ 0,0,0,0,0,  0,1,1,1,0,  0,1,1,1,0,  0,1,1,1,0,  0,0,0,0,0 },
        '{ 0,0,0,0,0,  0,1,2,1,0,  0,2,4,2,0,  0,1,2,1,0,  0,0,0,0,0 },
        '{ 1,4,6,4,1,  4,16,24,16,4,  6,24,36,24,6,  4,16,24,16,4,  1,4,6,4,1 },
        '{ -1,-4,-6,-4,-1,  -4,-16,-24,-16,-4,  -6,-24,476,-24,-6,
           -4,-16,-24,-16,-4,  -1,-4,-6,-4,-1 },
        '{ 0,0,0,0,0,  0,0,0,0,0,  0,0,0,0,0,  0,0,0,0,0,  0,0,0,0,0 }
    };

    // one color channel of a pixel, 0 red, 1 green, 2 blue
    function automatic logic [COLOR_BITS-1:0] chan(input t_pixel p, input int ch);
        logic [COLOR_BITS-1:0] v;
        case (ch)
            0:       v = p.red;
            1:       v = p.green;
            default: v = p.blue;
        endcase
        return v;
    endfunction

endpackage

// File: design/rkcf_if.sv
// ----------------------------------------------------------------------------
// rkcf channel interfaces
// Pixel input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface rkcf_in_if;
    import rkcf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [COLOR_BITS-1:0] in_red;
    logic [COLOR_BITS-1:0] in_green;
    logic [COLOR_BITS-1:0] in_blue;
    modport source (output valid, req_type, in_red, in_green, in_blue, input ready);
    modport sink   (input valid, req_type, in_red, in_green, in_blue, output ready);
endinterface

interface rkcf_out_if;
    import rkcf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [COLOR_BITS-1:0] out_red;
    logic [COLOR_BITS-1:0] out_green;
    logic [COLOR_BITS-1:0] out_blue;
    logic                  frame_end;
    modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

interface rkcf_cfg_if;
    import rkcf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: design/rgb_kernel_convolution_filter.sv
// ----------------------------------------------------------------------------
// rgb_kernel_convolution_filter
// Streaming 3x3 / 5x5 kernel filter for rgb888 pixels in raster order.
// ----------------------------------------------------------------------------
// Takes one item per clock unless back pressure fills the stages, and gives at
// most one result per item. An item passes a position stage with the line
// store read, a window stage, a row sum stage and the result register; each
// stage holds under back pressure, and the input keeps flowing while a
// finished result waits at the output until the stages behind it hold
// results too. In the pixel stream a result trails its pixel by
// 2*line_length+2 items; after the last pixel of a frame, flush items (or
// further pixels, whose data is dropped) push out the remaining results. A
// flush while pixels of the frame are still expected is taken and ignored.
// Configuration writes take effect at once and belong between frames, with
// the block empty.
// ----------------------------------------------------------------------------
module rgb_kernel_convolution_filter #(
    parameter int MAX_LINE_LENGTH = rkcf_pkg::MAX_LINE_LENGTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rkcf_in_if.sink    i_in,
    rkcf_out_if.source o_out,
    rkcf_cfg_if.sink   i_cfg
);
    import rkcf_pkg::*;

    localparam int ColW  = $clog2(MAX_LINE_LENGTH);
    localparam int LenW  = ($clog2(MAX_LINE_LENGTH + 1) > LEN_REG_W)
                           ? $clog2(MAX_LINE_LENGTH + 1) : LEN_REG_W;
    localparam int FillW = LenW + 2;

    // configuration
    t_mode                r_mode;
    logic [LEN_REG_W-1:0] r_line_length;
    logic [CNT_REG_W-1:0] r_line_count;

    // frame positions
    logic [ColW-1:0]  r_in_col;
    logic [ROW_W-1:0] r_in_row;
    logic [ColW-1:0]  r_out_col;
    logic [ROW_W-1:0] r_out_row;
    logic [FillW-1:0] r_fill;

    // pipeline
    logic      r_v1, r_v2, r_v3, r_v4;
    t_pixel    r_s1_pix;
    logic [1:0] r_s1_slot;
    t_res_ctrl r_s1_ctrl, r_s2_ctrl;
    logic      r_s3_last, r_s4_last;
    logic      en1, en2, en3, en4;

    logic [LenW-1:0]  eff_len;
    logic [ROW_W-1:0] eff_cnt;
    logic [FillW-1:0] lag;
    logic             draining, accept, step, emit, out_past, last, inner, res_valid;
    logic             restart;
    logic [ROW_W-1:0] rad_r;
    logic [LenW:0]    rad_c, out_col_x, in_col_inc;
    t_pixel           in_pix;
    t_pixel           rd_data [SLOTS];
    t_pixel           win [TAPS];
    t_pixel           res_pix;

    // pipeline flow control
    assign en4 = !r_v4 || o_out.ready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign i_in.ready  = en1;
    assign i_cfg.ready = 1'b1;

    // effective sizes
    always_comb begin
        if (r_line_length == '0) begin
            eff_len = LenW'(1);
        end else if (LenW'(r_line_length) > LenW'(MAX_LINE_LENGTH)) begin
            eff_len = LenW'(MAX_LINE_LENGTH);
        end else begin
            eff_len = LenW'(r_line_length);
        end
        eff_cnt = (r_line_count == '0) ? ROW_W'(1) : ROW_W'(r_line_count);
        lag     = FillW'({eff_len, 1'b0}) + FillW'(2);
    end

    // item decode and result position
    always_comb begin
        draining  = r_in_row >= eff_cnt;
        accept    = i_in.valid && en1;
        step      = accept && !(i_in.req_type && !draining);
        emit      = r_fill >= lag;
        out_past  = r_out_row >= eff_cnt;
        out_col_x = (LenW+1)'(r_out_col);
        rad_r     = (r_mode == MODE_GAUSS5 || r_mode == MODE_UNSHARP) ? ROW_W'(2) : ROW_W'(1);
        rad_c     = (LenW+1)'(rad_r[1:0]);
        inner     = (r_mode != MODE_COPY)
                    && (r_out_row >= rad_r) && (r_out_row + rad_r < eff_cnt)
                    && (out_col_x >= rad_c) && (out_col_x + rad_c < (LenW+1)'(eff_len));
        last      = (r_out_row + ROW_W'(1) >= eff_cnt)
                    && (out_col_x + (LenW+1)'(1) >= (LenW+1)'(eff_len));
        res_valid = step && emit && !out_past;
        restart   = step && emit && (out_past || last);
        in_col_inc = (LenW+1)'(r_in_col) + (LenW+1)'(1);
        in_pix    = draining ? t_pixel'('0)
                    : t_pixel'{red: i_in.in_red, green: i_in.in_green, blue: i_in.in_blue};
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_COPY;
            r_line_length <= LEN_REG_W'(320);
            r_line_count  <= CNT_REG_W'(240);
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_FILTER_MODE: r_mode        <= t_mode'(i_cfg.data[MODE_W-1:0]);
                CFG_LINE_LENGTH: r_line_length <= i_cfg.data[LEN_REG_W-1:0];
                CFG_LINE_COUNT:  r_line_count  <= i_cfg.data[CNT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // position and fill counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_fill    <= '0;
        end else if (restart) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_fill    <= '0;
        end else if (step) begin
            if (!emit) begin
                r_fill <= r_fill + FillW'(1);
            end
            if (in_col_inc >= (LenW+1)'(eff_len)) begin
                r_in_col <= '0;
                r_in_row <= r_in_row + ROW_W'(1);
            end else begin
                r_in_col <= ColW'(in_col_inc);
            end
            if (res_valid) begin
                if (out_col_x + (LenW+1)'(1) >= (LenW+1)'(eff_len)) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + ROW_W'(1);
                end else begin
                    r_out_col <= ColW'(out_col_x + (LenW+1)'(1));
                end
            end
        end
    end

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= step;
            if (en2) r_v2 <= r_v1 && r_s1_ctrl.res;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_s1_pix  <= in_pix;
            r_s1_slot <= r_in_row[1:0];
            r_s1_ctrl <= '{res: res_valid, mode: r_mode, inner: inner, last: last};
        end
        if (en2 && r_v1) r_s2_ctrl <= r_s1_ctrl;
        if (en3 && r_v2) r_s3_last <= r_s2_ctrl.last;
        if (en4 && r_v3) r_s4_last <= r_s3_last;
    end

    rkcf_line_store #(
        .DEPTH (MAX_LINE_LENGTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (step),
        .i_addr    (r_in_col),
        .i_wr_en   (step && !draining),
        .i_wr_slot (r_in_row[1:0]),
        .i_wr_data (in_pix),
        .o_rd_data (rd_data)
    );

    rkcf_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (r_v1 && en2),
        .i_slot  (r_s1_slot),
        .i_rd    (rd_data),
        .i_pix   (r_s1_pix),
        .o_win   (win)
    );

    rkcf_filter u_filter (
        .i_clk   (i_clk),
        .i_en_a  (r_v2 && en3),
        .i_en_b  (r_v3 && en4),
        .i_mode  (r_s2_ctrl.mode),
        .i_inner (r_s2_ctrl.inner),
        .i_win   (win),
        .o_pix   (res_pix)
    );

    // result channel
    assign o_out.valid     = r_v4;
    assign o_out.out_red   = res_pix.red;
    assign o_out.out_green = res_pix.green;
    assign o_out.out_blue  = res_pix.blue;
    assign o_out.frame_end = r_s4_last;

    // ignored flush leaves frame state alone
    a_flush_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.req_type && !draining)
        |=> $stable(r_fill) && $stable(r_in_col) && $stable(r_in_row))
        else $error("ignored flush moved frame state");

    // fill count stops once the lag is reached
    a_fill_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && emit) |=> (r_fill == '0) || $stable(r_fill))
        else $error("fill count moved after lag reached");

    // a stalled row sum stage keeps its item
    a_s3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !en3) |=> r_v3)
        else $error("row sum stage lost an item");

    // a new result comes only from the row sum stage
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(r_v3))
        else $error("result without a filtered item");

endmodule

// File: design/rkcf_line_store.sv
// ----------------------------------------------------------------------------
// rkcf_line_store
// Four line memories, one per row slot, read together at one column and
// written at one slot, with registered read data.
// ----------------------------------------------------------------------------
module rkcf_line_store #(
    parameter int DEPTH = rkcf_pkg::MAX_LINE_LENGTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic                  i_wr_en,
    input  logic [1:0]            i_wr_slot,
    input  rkcf_pkg::t_pixel      i_wr_data,
    output rkcf_pkg::t_pixel      o_rd_data [rkcf_pkg::SLOTS]
);
    import rkcf_pkg::*;

    for (genvar g = 0; g < SLOTS; g++) begin : g_slot
        t_pixel r_mem [DEPTH];
        t_pixel r_rd;

        // read old contents, write new pixel at the same column
        always_ff @(posedge i_clk) begin
            if (i_wr_en && (i_wr_slot == 2'(g))) begin
                r_mem[i_addr] <= i_wr_data;
            end
            if (i_rd_en) begin
                r_rd <= r_mem[i_addr];
            end
        end

        assign o_rd_data[g] = r_rd;
    end

endmodule

// File: design/rkcf_window.sv
// ----------------------------------------------------------------------------
// rkcf_window
// 5x5 pixel window: each item shifts in one new column built from the four
// stored lines and the incoming pixel.
// ----------------------------------------------------------------------------
module rkcf_window (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  logic [1:0]       i_slot,
    input  rkcf_pkg::t_pixel i_rd [rkcf_pkg::SLOTS],
    input  rkcf_pkg::t_pixel i_pix,
    output rkcf_pkg::t_pixel o_win [rkcf_pkg::TAPS]
);
    import rkcf_pkg::*;

    t_pixel col [KSIZE];
    t_pixel r_win [TAPS];

    // oldest line first, current pixel last
    always_comb begin
        for (int k = 0; k < SLOTS; k++) begin
            col[k] = i_rd[2'(i_slot + 2'(k))];
        end
        col[KSIZE-1] = i_pix;
    end

    // shift window left by one column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAPS; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_shift) begin
            for (int k = 0; k < KSIZE; k++) begin
                for (int j = 0; j < KSIZE - 1; j++) begin
                    r_win[k*KSIZE+j] <= r_win[k*KSIZE+j+1];
                end
                r_win[k*KSIZE+KSIZE-1] <= col[k];
            end
        end
    end

    assign o_win = r_win;

endmodule

// File: design/rkcf_filter.sv
// ----------------------------------------------------------------------------
// rkcf_filter
// Two stage kernel datapath: weighted row sums per channel, then total,
// clamp and divide, or pass the center pixel at image borders and in copy mode.
// ----------------------------------------------------------------------------
module rkcf_filter (
    input  logic             i_clk,
    input  logic             i_en_a,
    input  logic             i_en_b,
    input  rkcf_pkg::t_mode  i_mode,
    input  logic             i_inner,
    input  rkcf_pkg::t_pixel i_win [rkcf_pkg::TAPS],
    output rkcf_pkg::t_pixel o_pix
);
    import rkcf_pkg::*;

    localparam int          DIV9_SHIFT = 15;
    localparam logic [23:0] DIV9_MUL   = 24'd3641;

    logic signed [SUM_W-1:0] n_row [3][KSIZE];
    logic signed [SUM_W-1:0] r_row [3][KSIZE];
    t_mode                   r_mode;
    logic                    r_inner;
    t_pixel                  r_center;
    logic [COLOR_BITS-1:0]   n_res [3];
    t_pixel                  n_pix;
    t_pixel                  r_pix;

    // weighted sum of each window row
    always_comb begin
        logic signed [SUM_W-1:0] acc;
        for (int ch = 0; ch < 3; ch++) begin
            for (int k = 0; k < KSIZE; k++) begin
                acc = '0;
                for (int j = 0; j < KSIZE; j++) begin
                    acc = acc + SUM_W'(KERNEL[i_mode][k*KSIZE+j])
                              * $signed(SUM_W'(chan(i_win[k*KSIZE+j], ch)));
                end
                n_row[ch][k] = acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_a) begin
            r_row    <= n_row;
            r_mode   <= i_mode;
            r_inner  <= i_inner;
            r_center <= i_win[TAPS/2];
        end
    end

    // total, clamp to 0..255, divide by the mode's divisor
    always_comb begin
        logic signed [SUM_W-1:0] tot;
        logic [23:0]             prod;
        for (int ch = 0; ch < 3; ch++) begin
            tot = '0;
            for (int k = 0; k < KSIZE; k++) begin
                tot = tot + r_row[ch][k];
            end
            prod = 24'(tot[11:0]) * DIV9_MUL;
            if (tot < 0) begin
                n_res[ch] = '0;
            end else begin
                case (r_mode)
                    MODE_BOX: begin
                        n_res[ch] = (tot >= 2295) ? 8'hFF : prod[DIV9_SHIFT +: 8];
                    end
                    MODE_GAUSS3: begin
                        n_res[ch] = (tot >= 4080) ? 8'hFF : tot[11:4];
                    end
                    MODE_GAUSS5, MODE_UNSHARP: begin
                        n_res[ch] = (tot >= 65280) ? 8'hFF : tot[15:8];
                    end
                    default: begin
                        n_res[ch] = (tot >= 255) ? 8'hFF : tot[7:0];
                    end
                endcase
            end
        end
        if (r_inner) begin
            n_pix = '{red: n_res[0], green: n_res[1], blue: n_res[2]};
        end else begin
            n_pix = r_center;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_b) begin
            r_pix <= n_pix;
        end
    end

    assign o_pix = r_pix;

endmodule
